[sv/lfc_pkg.sv]
// ---------------------------------------------------------------------------
// lfc_pkg
// Types, codes and constants shared by the lift floor controller modules.
// ---------------------------------------------------------------------------
package lfc_pkg;

  // Event kinds on the input channel; the fourth code means nothing
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_SELECT = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_GUARD  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TRAVEL = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BLINK  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SETTLE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OPEN   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HOLD   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CLOSE  = 3'd6;

  localparam int unsigned TickW = 16;

  // Reset values of the tick counts
  localparam logic [TickW-1:0] GUARD_RST  = 16'd300;
  localparam logic [TickW-1:0] TRAVEL_RST = 16'd4000;
  localparam logic [TickW-1:0] BLINK_RST  = 16'd200;
  localparam logic [TickW-1:0] SETTLE_RST = 16'd1000;
  localparam logic [TickW-1:0] OPEN_RST   = 16'd1000;
  localparam logic [TickW-1:0] HOLD_RST   = 16'd2000;
  localparam logic [TickW-1:0] CLOSE_RST  = 16'd1000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_GUARD,
    PH_TRAVEL,
    PH_BLINK,
    PH_SETTLE,
    PH_OPEN,
    PH_HOLD,
    PH_CLOSE
  } phase_e;

  typedef struct packed {
    logic [TickW-1:0] guard_ticks;
    logic [TickW-1:0] travel_ticks;
    logic [TickW-1:0] blink_ticks;
    logic [TickW-1:0] settle_ticks;
    logic [TickW-1:0] open_ticks;
    logic [TickW-1:0] hold_ticks;
    logic [TickW-1:0] close_ticks;
  } cfg_t;

  typedef struct packed {
    logic       motor_up;
    logic       motor_down;
    logic       door_open_drive;
    logic       door_close_drive;
    logic       floor_lamp;
    logic [6:0] target_segments;
    logic [6:0] current_segments;
    logic       busy_res;
  } res_t;

  // Seven-segment code, bit 0 is segment a
  function automatic logic [6:0] seg_code(input logic [1:0] flr);
    logic [6:0] code;
    case (flr)
      2'd0:    code = 7'h3f;
      2'd1:    code = 7'h06;
      2'd2:    code = 7'h5b;
      default: code = 7'h4f;
    endcase
    return code;
  endfunction

endpackage

[sv/lfc_if.sv]
// ---------------------------------------------------------------------------
// lfc_if
// Channel interfaces of the lift floor controller: events, results, config.
// ---------------------------------------------------------------------------
interface lfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] floor;

  modport source (output valid, func, floor, input ready);
  modport sink   (input valid, func, floor, output ready);
endinterface

interface lfc_out_if;
  logic       valid;
  logic       ready;
  logic       motor_up;
  logic       motor_down;
  logic       door_open_drive;
  logic       door_close_drive;
  logic       floor_lamp;
  logic [6:0] target_segments;
  logic [6:0] current_segments;
  logic       busy_res;

  modport source (output valid, motor_up, motor_down, door_open_drive, door_close_drive,
                  floor_lamp, target_segments, current_segments, busy_res,
                  input ready);
  modport sink   (input valid, motor_up, motor_down, door_open_drive, door_close_drive,
                  floor_lamp, target_segments, current_segments, busy_res,
                  output ready);
endinterface

interface lfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/lfc_cfg_regs.sv]
// ---------------------------------------------------------------------------
// lfc_cfg_regs
// Register file holding the seven phase tick counts.
// ---------------------------------------------------------------------------
module lfc_cfg_regs
  import lfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  lfc_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.guard_ticks  <= GUARD_RST;
      cfg_q.travel_ticks <= TRAVEL_RST;
      cfg_q.blink_ticks  <= BLINK_RST;
      cfg_q.settle_ticks <= SETTLE_RST;
      cfg_q.open_ticks   <= OPEN_RST;
      cfg_q.hold_ticks   <= HOLD_RST;
      cfg_q.close_ticks  <= CLOSE_RST;
    end else if (wr_en) begin
      case (cfg_i.index)
        REG_GUARD:  cfg_q.guard_ticks  <= cfg_i.data;
        REG_TRAVEL: cfg_q.travel_ticks <= cfg_i.data;
        REG_BLINK:  cfg_q.blink_ticks  <= cfg_i.data;
        REG_SETTLE: cfg_q.settle_ticks <= cfg_i.data;
        REG_OPEN:   cfg_q.open_ticks   <= cfg_i.data;
        REG_HOLD:   cfg_q.hold_ticks   <= cfg_i.data;
        REG_CLOSE:  cfg_q.close_ticks  <= cfg_i.data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/lfc_seq.sv]
// ---------------------------------------------------------------------------
// lfc_seq
// Lift sequencer state: phase, timer, floors; applies one event per enable.
// ---------------------------------------------------------------------------
module lfc_seq
  import lfc_pkg::*;
#(
  parameter int NUM_FLOORS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [1:0] func_i,
  input  logic [1:0] floor_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  localparam logic [3:0] FloorLimit = 4'(NUM_FLOORS);

  phase_e           phase_q, phase_d;
  logic [TickW-1:0] timer_q, timer_d;
  logic [1:0]       cur_q, cur_d;
  logic [1:0]       tgt_q, tgt_d;
  logic [1:0]       left_q, left_d;
  logic             up_q, up_d;
  logic             start_q, start_d;
  logic             moving;
  logic             sel_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      cur_q   <= '0;
      tgt_q   <= '0;
      left_q  <= '0;
      up_q    <= 1'b0;
      start_q <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      cur_q   <= cur_d;
      tgt_q   <= tgt_d;
      left_q  <= left_d;
      up_q    <= up_d;
      start_q <= start_d;
    end
  end

  assign sel_ok = ({2'b00, floor_i} < FloorLimit);

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    cur_d   = cur_q;
    tgt_d   = tgt_q;
    left_d  = left_q;
    up_d    = up_q;
    start_d = start_q;
    case (func_i)
      FUNC_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (timer_q > 16'd1) begin
            timer_d = timer_q - 16'd1;
          end else begin
            // phase over: enter the next one
            case (phase_q)
              PH_GUARD: begin
                if (start_q) begin
                  start_d = 1'b0;
                  up_d    = (tgt_q > cur_q);
                  left_d  = up_d ? (tgt_q - cur_q) : (cur_q - tgt_q);
                  if (left_d != 2'd0) begin
                    phase_d = PH_TRAVEL;
                    timer_d = cfg_i.travel_ticks;
                  end else begin
                    phase_d = PH_SETTLE;
                    timer_d = cfg_i.settle_ticks;
                  end
                end else begin
                  phase_d = PH_IDLE;
                  timer_d = '0;
                end
              end
              PH_TRAVEL: begin
                cur_d   = up_q ? (cur_q + 2'd1) : (cur_q - 2'd1);
                left_d  = left_q - 2'd1;
                phase_d = PH_BLINK;
                timer_d = cfg_i.blink_ticks;
              end
              PH_BLINK: begin
                if (left_q != 2'd0) begin
                  phase_d = PH_TRAVEL;
                  timer_d = cfg_i.travel_ticks;
                end else begin
                  phase_d = PH_SETTLE;
                  timer_d = cfg_i.settle_ticks;
                end
              end
              PH_SETTLE: begin
                phase_d = PH_OPEN;
                timer_d = cfg_i.open_ticks;
              end
              PH_OPEN: begin
                phase_d = PH_HOLD;
                timer_d = cfg_i.hold_ticks;
              end
              PH_HOLD: begin
                phase_d = PH_CLOSE;
                timer_d = cfg_i.close_ticks;
              end
              default: begin
                phase_d = PH_IDLE;
                timer_d = '0;
              end
            endcase
          end
        end
      end
      FUNC_SELECT: begin
        if (phase_q == PH_IDLE && sel_ok) begin
          tgt_d   = floor_i;
          start_d = 1'b0;
          phase_d = PH_GUARD;
          timer_d = cfg_i.guard_ticks;
        end
      end
      FUNC_START: begin
        if (phase_q == PH_IDLE) begin
          start_d = 1'b1;
          phase_d = PH_GUARD;
          timer_d = cfg_i.guard_ticks;
        end
      end
      default: ;  // unused code: no effect
    endcase
  end

  // Result reflects the state after the event
  assign moving = (phase_d == PH_TRAVEL) || (phase_d == PH_BLINK);

  always_comb begin
    res_o.motor_up         = moving && up_d;
    res_o.motor_down       = moving && !up_d;
    res_o.door_open_drive  = (phase_d == PH_OPEN);
    res_o.door_close_drive = (phase_d == PH_CLOSE);
    res_o.floor_lamp       = (phase_d == PH_BLINK);
    res_o.target_segments  = seg_code(tgt_d);
    res_o.current_segments = seg_code(cur_d);
    res_o.busy_res         = (phase_d != PH_IDLE);
  end

  // Floors still to travel only while the car is on its way
  a_left_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q != 2'd0) |-> (phase_q == PH_TRAVEL || phase_q == PH_BLINK))
    else $error("floors left outside travel");

  a_travel_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TRAVEL) |-> (left_q != 2'd0))
    else $error("travel phase with no floors left");

  a_target_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |=> $stable(tgt_q))
    else $error("target changed while busy");

  a_cur_travel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_TRAVEL) |=> $stable(cur_q))
    else $error("current floor changed outside travel");

endmodule

[sv/lift_floor_controller.sv]
// ---------------------------------------------------------------------------
// lift_floor_controller
// Four-floor lift sequencer driven by tick, floor-select and start events.
//
// Takes one event transfer per clock and returns exactly one result transfer
// for it, showing motor, door, lamp, display and busy state after the event.
// An input register holds the event, the sequencer applies it to the lift
// state and the outcome lands in the result register. The two stages stall
// together only while a result waits to be taken with the input stage also
// full, so with a ready sink the sustained rate is one event per clock. Tick
// counts are written through the configuration channel (always ready), by
// the user only while no event is in flight; the block does not enforce it.
// Indexes above six are dropped. Floor selects >= NUM_FLOORS are ignored.
// ---------------------------------------------------------------------------
module lift_floor_controller
  import lfc_pkg::*;
#(
  parameter int NUM_FLOORS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lfc_in_if.sink     in_i,
  lfc_out_if.source  out_o,
  lfc_cfg_if.sink    cfg_i
);

  cfg_t       cfg;
  res_t       res_d, res_q;
  logic       s1_valid_q;
  logic [1:0] s1_func_q;
  logic [1:0] s1_floor_q;
  logic       res_valid_q;
  logic       s1_adv;
  logic       in_xfer;
  logic       step_en;

  // Advance the input stage when the result register is free or being drained
  assign s1_adv   = !res_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer  = in_i.valid && in_i.ready;
  assign step_en  = s1_valid_q && s1_adv;

  lfc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  lfc_seq #(
    .NUM_FLOORS (NUM_FLOORS)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (step_en),
    .func_i  (s1_func_q),
    .floor_i (s1_floor_q),
    .cfg_i   (cfg),
    .res_o   (res_d)
  );

  // Input stage: hold the event until the sequencer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_func_q  <= in_i.func;
      s1_floor_q <= in_i.floor;
    end
  end

  // Result stage: hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = res_valid_q;
  assign out_o.motor_up         = res_q.motor_up;
  assign out_o.motor_down       = res_q.motor_down;
  assign out_o.door_open_drive  = res_q.door_open_drive;
  assign out_o.door_close_drive = res_q.door_close_drive;
  assign out_o.floor_lamp       = res_q.floor_lamp;
  assign out_o.target_segments  = res_q.target_segments;
  assign out_o.current_segments = res_q.current_segments;
  assign out_o.busy_res         = res_q.busy_res;

endmodule
